@@ src/rlid_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlid_pkg
// shared types and constants of the run-length image decoder
// ----------------------------------------------------------------------------
package rlid_pkg;

    localparam int LEN_BITS  = 16;
    localparam int BYTE_BITS = 8;
    localparam int CFG_BITS  = 24;

    localparam logic [BYTE_BITS-1:0] FILL_BYTE = 8'hF6;

    // request kinds carried in the input tuser
    typedef enum logic [1:0] {
        REQ_BYTE = 2'd0,
        REQ_EOF  = 2'd1,
        REQ_TICK = 2'd2
    } req_t;

    // decoder phase
    typedef enum logic [2:0] {
        PH_LEN_LO   = 3'd0,
        PH_LEN_HI   = 3'd1,
        PH_REP_BYTE = 3'd2,
        PH_LITERAL  = 3'd3,
        PH_RUN      = 3'd4,
        PH_FILL     = 3'd5,
        PH_STOPPED  = 3'd6
    } phase_t;

    // one input beat as held in the input register
    typedef struct packed {
        logic [1:0]           req;
        logic [BYTE_BITS-1:0] data;
    } item_t;

    // result of one decode step
    typedef struct packed {
        logic                 valid;
        logic [BYTE_BITS-1:0] data;
        logic                 last;
        logic                 corrupt;
    } res_t;

endpackage

@@ src/run_length_image_decoder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// run_length_image_decoder
// streaming decoder for the run-length coded body of a disk image
// ----------------------------------------------------------------------------
// The block takes one beat per clock cycle while the master side takes its
// results, and gives at most one decoded byte per beat, which reaches the master
// side through the input register, the decode step and the result register. The
// rate is set by the one decode step between the registers: the record state
// it updates feeds the very next beat. A beat on
// the slave side is a file byte, an end-of-file mark or a tick; file bytes
// carry the signed little-endian record lengths, literal bytes and repeat
// bytes, while each tick releases one byte of a pending repeat run or of the
// 0xF6 fill that follows an end of file at a record boundary. An end of file
// inside a record but outside a repeat run gives one beat with tuser set and
// data zero, and the block then stays silent until reset. Once the configured
// image size is reached every beat is swallowed; a larger size written later
// resumes decoding. Write the image size only while no beat is in flight.
// Reset leaves nothing to clear beyond the control registers.
// ----------------------------------------------------------------------------
module run_length_image_decoder
    import rlid_pkg::*;
#(
    parameter int POSITION_BITS = 24
)
(
    input  logic        clk,
    input  logic        rst_n,
    // slave side
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // in_byte[7:0]
    input  logic [1:0]  s_tuser,   // req_type[1:0]
    // master side
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // out_byte[7:0]
    output logic        m_tlast,   // last_byte
    output logic        m_tuser,   // corrupt
    // image size register
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [23:0] cfg_data   // image_bytes[23:0]
);

    item_t item;
    res_t  res;
    logic  item_valid;
    logic  out_free;
    logic  advance;

    // the held beat is decoded once the result register can take its result
    assign advance   = item_valid && out_free;
    // size register is always writable
    assign cfg_ready = 1'b1;

    rlid_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    rlid_core #(
        .POSITION_BITS (POSITION_BITS)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data),
        .advance   (advance),
        .item      (item),
        .res       (res)
    );

    rlid_out_stage u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (advance),
        .res      (res),
        .free     (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

@@ src/rlid_in_stage.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlid_in_stage
// input register; takes a new beat when empty or when the held one moves on
// ----------------------------------------------------------------------------
module rlid_in_stage
    import rlid_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // in_byte[7:0]
    input  logic [1:0] s_tuser,   // req_type[1:0]
    input  logic       advance,
    output logic       item_valid,
    output item_t      item
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    logic  load;

    assign s_tready = !valid_reg || advance;
    assign load     = s_tvalid && s_tready;

    always_comb
    begin
        if (load)
            valid_next = 1'b1;
        else if (advance)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg.req  <= s_tuser;
            item_reg.data <= s_tdata;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

@@ src/rlid_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlid_core
// record decoder state and the single-step decode of one beat
// ----------------------------------------------------------------------------
module rlid_core
    import rlid_pkg::*;
#(
    parameter int POSITION_BITS = 24
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_write,
    input  logic [CFG_BITS-1:0] cfg_data,
    input  logic                advance,
    input  item_t               item,
    output res_t                res
);

    localparam int CW = (POSITION_BITS > CFG_BITS) ? POSITION_BITS : CFG_BITS;

    phase_t                   phase_reg, phase_next;
    logic [BYTE_BITS-1:0]     length_low_reg, length_low_next;
    logic [LEN_BITS-1:0]      run_remaining_reg, run_remaining_next;
    logic [BYTE_BITS-1:0]     run_value_reg, run_value_next;
    logic [POSITION_BITS-1:0] write_position_reg, write_position_next;
    logic [CFG_BITS-1:0]      image_bytes_reg;

    logic [CW-1:0]            img_ext;
    logic [CW-1:0]            max_ext;
    logic [CW-1:0]            limit_ext;
    logic [POSITION_BITS-1:0] limit;
    logic [POSITION_BITS-1:0] pos_inc;
    logic [LEN_BITS-1:0]      len;
    logic [LEN_BITS-1:0]      rem_dec;
    logic                     active;
    logic                     emit;
    req_t                     req;

    // image size clipped to what the position counter can hold
    assign img_ext   = CW'(image_bytes_reg);
    assign max_ext   = CW'({POSITION_BITS{1'b1}});
    assign limit_ext = (img_ext < max_ext) ? img_ext : max_ext;
    assign limit     = limit_ext[POSITION_BITS-1:0];

    assign active  = (phase_reg != PH_STOPPED) && (write_position_reg < limit);
    assign req     = req_t'(item.req);
    assign len     = {item.data, length_low_reg};
    assign rem_dec = run_remaining_reg - LEN_BITS'(1);
    assign pos_inc = write_position_reg + POSITION_BITS'(1);

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (active)
        begin
            unique case (phase_reg)
                PH_LEN_LO:
                begin
                    if (req == REQ_BYTE)
                        phase_next = PH_LEN_HI;
                    else if (req == REQ_EOF)
                        phase_next = PH_FILL;
                end
                PH_LEN_HI:
                begin
                    if (req == REQ_BYTE)
                    begin
                        if (len == '0)
                            phase_next = PH_LEN_LO;
                        else if (len[LEN_BITS-1])
                            phase_next = PH_REP_BYTE;
                        else
                            phase_next = PH_LITERAL;
                    end
                    else if (req == REQ_EOF)
                        phase_next = PH_STOPPED;
                end
                PH_REP_BYTE:
                begin
                    if (req == REQ_BYTE)
                        phase_next = PH_RUN;
                    else if (req == REQ_EOF)
                        phase_next = PH_STOPPED;
                end
                PH_LITERAL:
                begin
                    if (req == REQ_BYTE)
                    begin
                        if (rem_dec == '0)
                            phase_next = PH_LEN_LO;
                    end
                    else if (req == REQ_EOF)
                        phase_next = PH_STOPPED;
                end
                PH_RUN:
                begin
                    if (req == REQ_TICK && rem_dec == '0)
                        phase_next = PH_LEN_LO;
                end
                PH_FILL:    phase_next = PH_FILL;
                PH_STOPPED: phase_next = PH_STOPPED;
                default:    phase_next = phase_reg;
            endcase
        end
    end

    // datapath and result
    always_comb
    begin
        length_low_next    = length_low_reg;
        run_remaining_next = run_remaining_reg;
        run_value_next     = run_value_reg;
        emit               = 1'b0;
        res                = '0;
        if (active)
        begin
            unique case (phase_reg)
                PH_LEN_LO:
                begin
                    if (req == REQ_BYTE)
                        length_low_next = item.data;
                end
                PH_LEN_HI:
                begin
                    if (req == REQ_BYTE)
                        run_remaining_next = len[LEN_BITS-1] ? (~len + LEN_BITS'(1)) : len;
                    else if (req == REQ_EOF)
                    begin
                        res.valid   = 1'b1;
                        res.corrupt = 1'b1;
                    end
                end
                PH_REP_BYTE:
                begin
                    if (req == REQ_BYTE)
                        run_value_next = item.data;
                    else if (req == REQ_EOF)
                    begin
                        res.valid   = 1'b1;
                        res.corrupt = 1'b1;
                    end
                end
                PH_LITERAL:
                begin
                    if (req == REQ_BYTE)
                    begin
                        run_remaining_next = rem_dec;
                        emit               = 1'b1;
                        res.data           = item.data;
                    end
                    else if (req == REQ_EOF)
                    begin
                        res.valid   = 1'b1;
                        res.corrupt = 1'b1;
                    end
                end
                PH_RUN:
                begin
                    if (req == REQ_TICK)
                    begin
                        run_remaining_next = rem_dec;
                        emit               = 1'b1;
                        res.data           = run_value_reg;
                    end
                end
                PH_FILL:
                begin
                    if (req == REQ_TICK)
                    begin
                        emit     = 1'b1;
                        res.data = FILL_BYTE;
                    end
                end
                PH_STOPPED: emit = 1'b0;
                default:    emit = 1'b0;
            endcase
        end
        if (emit)
        begin
            res.valid = 1'b1;
            res.last  = (pos_inc >= limit);
        end
        write_position_next = emit ? pos_inc : write_position_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= PH_LEN_LO;
            length_low_reg     <= '0;
            run_remaining_reg  <= '0;
            run_value_reg      <= '0;
            write_position_reg <= '0;
        end
        else if (advance)
        begin
            phase_reg          <= phase_next;
            length_low_reg     <= length_low_next;
            run_remaining_reg  <= run_remaining_next;
            run_value_reg      <= run_value_next;
            write_position_reg <= write_position_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            image_bytes_reg <= '0;
        else if (cfg_write)
            image_bytes_reg <= cfg_data;
    end

endmodule

@@ src/rlid_out_stage.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlid_out_stage
// result register toward the master side
// ----------------------------------------------------------------------------
module rlid_out_stage
    import rlid_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       advance,
    input  res_t       res,
    output logic       free,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // out_byte[7:0]
    output logic       m_tlast,
    output logic       m_tuser    // corrupt
);

    logic valid_reg;
    logic valid_next;
    logic load;
    logic [BYTE_BITS-1:0] data_reg;
    logic last_reg;
    logic corrupt_reg;

    assign free = !valid_reg || m_tready;
    assign load = advance && res.valid;

    always_comb
    begin
        if (load)
            valid_next = 1'b1;
        else if (m_tready)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg    <= res.data;
            last_reg    <= res.last;
            corrupt_reg <= res.corrupt;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tlast  = last_reg;
    assign m_tuser  = corrupt_reg;

endmodule

@@ src/rlid_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlid_checker
// port-level checks of the run-length image decoder
// ----------------------------------------------------------------------------
module rlid_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast,
    input logic       m_tuser
);

    // corruption beat carries no image byte
    a_corrupt_clean: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> (m_tdata == 8'h00) && !m_tlast)
        else $error("corrupt beat with data or last set");

    // no beat directly follows the end of the image or a corruption beat
    a_quiet_after_end: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && (m_tlast || m_tuser) |=> !m_tvalid)
        else $error("beat right after last or corrupt beat");

    // stalled beat holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)
            && $stable(m_tlast) && $stable(m_tuser))
        else $error("stalled output beat changed");

endmodule

bind run_length_image_decoder rlid_checker u_rlid_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);

@@ tb/tb_run_length_image_decoder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_run_length_image_decoder
// self-checking bench for the streaming run-length image decoder
// ----------------------------------------------------------------------------
// Beats go in on the slave side with random gaps. An in-bench model of the
// record decoder predicts every output beat when its input beat is taken.
// A sink process applies random back-pressure and checks each output beat
// against the oldest prediction. Tests cover an image size of zero, every
// record kind, the ignored requests, output back-pressure, long literal and
// repeat records, random record streams across many image sizes, and one of
// the end-of-file cases (fill or corruption), picked at random.
// ----------------------------------------------------------------------------
module tb_run_length_image_decoder;
    import rlid_pkg::*;

    localparam int CLK_PERIOD   = 4;
    localparam int RESET_CYCLES = 11;
    localparam int MAX_GAP      = 17;
    localparam int DRAIN_CYCLES = 8;       // pipeline is two deep, leave margin
    localparam int DRAIN_LIMIT  = 20000;
    localparam int HOLD_CYCLES  = 300;
    localparam int RANDOM_ITEMS = 440;
    localparam int LIMIT_CYCLES = 500000;
    localparam int MAX_REPORTS  = 10;

    localparam logic [1:0]  REQ_UNUSED = 2'd3;     // request code with no meaning
    localparam logic [23:0] SIZE_MAX   = 24'hFFFFFF;

    // terminal scenario, only one fits in a run since both states are sticky
    typedef enum int {
        END_FILL,
        END_AFTER_LOW,
        END_BEFORE_REPEAT,
        END_IN_LITERAL
    } eof_case_t;

    typedef struct {
        logic [7:0] data;
        logic       last;
        logic       corrupt;
    } out_beat_t;

    logic        clk;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = '0;   // in_byte[7:0]
    logic [1:0]  s_tuser   = '0;   // req_type[1:0]
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [7:0]  m_tdata;          // out_byte[7:0]
    logic        m_tlast;          // last_byte
    logic        m_tuser;          // corrupt
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [23:0] cfg_data  = '0;   // image_bytes[23:0]

    // predicted output beats, oldest first
    out_beat_t   decoded_due[$];
    int          fail_count = 0;

    // decoder model state
    phase_t      dec_phase   = PH_LEN_LO;
    logic [7:0]  len_lo_byte = '0;
    logic [15:0] run_left    = '0;
    logic [7:0]  run_byte    = '0;
    logic [23:0] write_pos   = '0;
    logic [23:0] size_model  = '0;

    // stimulus knobs
    logic [15:0] next_len   = '0;      // length of the record being sent
    bit          tx_steady  = 1'b0;    // sender without gaps
    bit          rx_steady  = 1'b0;    // sink without stalls
    bit          hold_kick  = 1'b0;    // toggle starts a long sink stall
    logic        rx_hold    = 1'b0;

    run_length_image_decoder uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
    end

    // run limit
    initial
    begin
        #(LIMIT_CYCLES * CLK_PERIOD);
        $display("FAIL");
        $finish;
    end

    // idle cycles before a beat, at least half of the beats come back to back
    function automatic int draw_gap(input bit steady);
        if (steady || $urandom_range(0, 1) == 0)
            return 0;
        return $urandom_range(0, MAX_GAP);
    endfunction

    function automatic void push_byte(input logic [7:0] value);
        out_beat_t b;
        write_pos = write_pos + 24'd1;
        b.data    = value;
        b.last    = (write_pos >= size_model);
        b.corrupt = 1'b0;
        decoded_due.push_back(b);
    endfunction

    // one request of the decoder, queues the beat it produces if any
    function automatic void decode_step(input logic [1:0] req, input logic [7:0] data);
        logic [15:0] rec_len;
        out_beat_t   bad;
        // stopped after corruption, or the image is already complete
        if (dec_phase == PH_STOPPED || write_pos >= size_model)
            return;
        case (req)
            REQ_BYTE:
            begin
                case (dec_phase)
                    PH_LEN_LO:
                    begin
                        len_lo_byte = data;
                        dec_phase   = PH_LEN_HI;
                    end
                    PH_LEN_HI:
                    begin
                        rec_len = {data, len_lo_byte};
                        if (rec_len == 16'd0)
                            dec_phase = PH_LEN_LO;
                        else if (rec_len[15])
                        begin
                            run_left  = 16'(16'd0 - rec_len);
                            dec_phase = PH_REP_BYTE;
                        end
                        else
                        begin
                            run_left  = rec_len;
                            dec_phase = PH_LITERAL;
                        end
                    end
                    PH_REP_BYTE:
                    begin
                        run_byte  = data;
                        dec_phase = PH_RUN;
                    end
                    PH_LITERAL:
                    begin
                        run_left = run_left - 16'd1;
                        if (run_left == 16'd0)
                            dec_phase = PH_LEN_LO;
                        push_byte(data);
                    end
                    default: ;  // bytes during a run or the fill are dropped
                endcase
            end
            REQ_EOF:
            begin
                if (dec_phase == PH_LEN_LO)
                    dec_phase = PH_FILL;
                else if (dec_phase == PH_LEN_HI || dec_phase == PH_REP_BYTE ||
                         dec_phase == PH_LITERAL)
                begin
                    dec_phase   = PH_STOPPED;
                    bad.data    = 8'd0;
                    bad.last    = 1'b0;
                    bad.corrupt = 1'b1;
                    decoded_due.push_back(bad);
                end
            end
            REQ_TICK:
            begin
                if (dec_phase == PH_RUN)
                begin
                    run_left = run_left - 16'd1;
                    if (run_left == 16'd0)
                        dec_phase = PH_LEN_LO;
                    push_byte(run_byte);
                end
                else if (dec_phase == PH_FILL)
                    push_byte(FILL_BYTE);
            end
            default: ;
        endcase
    endfunction

    // offer one beat, predict its output once it is taken
    task automatic put_beat(input logic [1:0] kind, input logic [7:0] data);
        int gap;
        gap = draw_gap(tx_steady);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= data;
        do
            @(posedge clk);
        while (s_tready !== 1'b1);
        decode_step(kind, data);
    endtask

    // stop offering, wait for every predicted beat and the pipeline to empty
    task automatic drain();
        int waited;
        waited = 0;
        s_tvalid <= 1'b0;
        while (decoded_due.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // image size write, only with the decoder idle
    task automatic write_size(input logic [23:0] size);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= size;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        cfg_valid  <= 1'b0;
        size_model = size;
    endtask

    // mostly short records, now and then a long one, some empty
    function automatic logic [15:0] pick_length();
        int unsigned mag;
        mag = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 600) : $urandom_range(1, 12);
        case ($urandom_range(0, 8))
            0:          return 16'd0;
            1, 2, 3, 4: return 16'(mag);
            default:    return 16'(32'd0 - mag);
        endcase
    endfunction

    // next beat of a well-formed stream, following the model phase
    task automatic send_wellformed();
        case (dec_phase)
            PH_LEN_LO:
            begin
                next_len = pick_length();
                put_beat(REQ_BYTE, next_len[7:0]);
            end
            PH_LEN_HI: put_beat(REQ_BYTE, next_len[15:8]);
            PH_RUN:    put_beat(REQ_TICK, 8'($urandom));
            default:   put_beat(REQ_BYTE, 8'($urandom));
        endcase
    endtask

    // a beat the decoder must ignore in the current phase
    task automatic send_noise();
        if (dec_phase == PH_RUN)
        begin
            case ($urandom_range(0, 2))
                0:       put_beat(REQ_BYTE, 8'($urandom));
                1:       put_beat(REQ_EOF, 8'($urandom));
                default: put_beat(REQ_UNUSED, 8'($urandom));
            endcase
        end
        else if ($urandom_range(0, 1) == 0)
            put_beat(REQ_TICK, 8'($urandom));
        else
            put_beat(REQ_UNUSED, 8'($urandom));
    endtask

    // image size is zero after reset, so nothing may come out
    task automatic test_size_zero();
        put_beat(REQ_BYTE, 8'h01);
        put_beat(REQ_BYTE, 8'h00);
        put_beat(REQ_BYTE, 8'h55);
    endtask

    // empty, literal and repeat records, ignored requests, image end on a run
    task automatic test_record_kinds();
        write_size(24'd6);
        put_beat(REQ_BYTE, 8'h00);      // empty record
        put_beat(REQ_BYTE, 8'h00);
        put_beat(REQ_BYTE, 8'h01);      // one literal
        put_beat(REQ_BYTE, 8'h00);
        put_beat(REQ_BYTE, 8'h00);
        put_beat(REQ_BYTE, 8'h02);      // two literals
        put_beat(REQ_BYTE, 8'h00);
        put_beat(REQ_BYTE, 8'hFF);
        put_beat(REQ_BYTE, 8'h80);
        put_beat(REQ_TICK, 8'h00);      // tick with nothing pending
        put_beat(REQ_BYTE, 8'hFD);      // repeat three times
        put_beat(REQ_BYTE, 8'hFF);
        put_beat(REQ_BYTE, 8'hAA);
        put_beat(REQ_TICK, 8'h00);
        put_beat(REQ_BYTE, 8'h12);      // file byte during the run
        put_beat(REQ_UNUSED, 8'hFF);
        put_beat(REQ_EOF, 8'h00);       // end of file during the run
        put_beat(REQ_TICK, 8'h00);
        put_beat(REQ_TICK, 8'h00);      // completes the image
        put_beat(REQ_TICK, 8'h00);      // dropped, image complete
        put_beat(REQ_BYTE, 8'h00);
    endtask

    // sink stalls for a long stretch while the sender keeps pushing
    task automatic test_output_stall();
        write_size(24'(write_pos + 24'd200));
        tx_steady = 1'b1;
        hold_kick <= ~hold_kick;
        put_beat(REQ_BYTE, 8'd48);
        put_beat(REQ_BYTE, 8'h00);
        repeat (48) put_beat(REQ_BYTE, 8'($urandom));
        put_beat(REQ_BYTE, 8'(-8'sd40));
        put_beat(REQ_BYTE, 8'hFF);
        put_beat(REQ_BYTE, 8'($urandom));
        repeat (40) put_beat(REQ_TICK, 8'($urandom));
        tx_steady = 1'b0;
    endtask

    // long repeat run and long literal record, at full rate
    task automatic test_long_records();
        write_size(SIZE_MAX);
        tx_steady = 1'b1;
        rx_steady = 1'b1;
        put_beat(REQ_BYTE, 8'h80);      // length -128
        put_beat(REQ_BYTE, 8'hFF);
        put_beat(REQ_BYTE, 8'hC3);
        repeat (128) put_beat(REQ_TICK, 8'($urandom));
        put_beat(REQ_BYTE, 8'h80);      // length 128
        put_beat(REQ_BYTE, 8'h00);
        repeat (128) put_beat(REQ_BYTE, 8'($urandom));
        tx_steady = 1'b0;
        rx_steady = 1'b0;
    endtask

    // random record streams, each phase ends at a new image size
    task automatic test_random_records();
        int sent;
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 9) == 0)
                write_size(write_pos);  // no room, everything dropped
            else
                write_size(24'(write_pos + 24'($urandom_range(20, 160))));
            tx_steady = ($urandom_range(0, 3) == 0);
            rx_steady = ($urandom_range(0, 3) == 0);
            while (write_pos < size_model && sent < RANDOM_ITEMS)
            begin
                if ($urandom_range(0, 9) == 0)
                    send_noise();
                else
                begin
                    send_wellformed();
                    sent++;
                end
            end
            // beats past the end of the image are swallowed
            if (write_pos >= size_model)
                repeat ($urandom_range(0, 3)) put_beat(2'($urandom), 8'($urandom));
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;
    endtask

    // end of file at a record boundary or inside one
    task automatic test_end_of_file();
        eof_case_t pick;
        pick = eof_case_t'($urandom_range(0, 3));
        write_size(SIZE_MAX);
        while (dec_phase != PH_LEN_LO)
            send_wellformed();
        case (pick)
            END_FILL:
            begin
                put_beat(REQ_EOF, 8'($urandom));
                repeat (20) put_beat(REQ_TICK, 8'($urandom));
                put_beat(REQ_BYTE, 8'($urandom));   // dropped during the fill
                put_beat(REQ_EOF, 8'($urandom));
                write_size(24'(write_pos + 24'd5));
                repeat (8) put_beat(REQ_TICK, 8'($urandom));
            end
            END_AFTER_LOW:
            begin
                put_beat(REQ_BYTE, 8'h04);
                put_beat(REQ_EOF, 8'($urandom));
            end
            END_BEFORE_REPEAT:
            begin
                put_beat(REQ_BYTE, 8'hFE);
                put_beat(REQ_BYTE, 8'hFF);
                put_beat(REQ_EOF, 8'($urandom));
            end
            default:
            begin
                put_beat(REQ_BYTE, 8'h03);
                put_beat(REQ_BYTE, 8'h00);
                put_beat(REQ_BYTE, 8'h99);
                put_beat(REQ_EOF, 8'($urandom));
            end
        endcase
        // complete image or stopped decoder, nothing more gets through
        repeat (6) put_beat(2'($urandom), 8'($urandom));
        write_size(24'd0);
        repeat (4) put_beat(2'($urandom), 8'($urandom));
    endtask

    // long sink stall, counted here so the sender keeps running meanwhile
    initial
    begin : sink_hold_timer
        bit seen;
        int left;
        seen = 1'b0;
        left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_kick != seen)
            begin
                seen = hold_kick;
                left = HOLD_CYCLES;
            end
            else if (left > 0)
                left--;
            rx_hold <= (left > 0);
        end
    end

    // sink with random stalls, checks every output beat
    initial
    begin : result_sink
        int        gap;
        out_beat_t want;
        gap = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n === 1'b1 && m_tvalid === 1'b1 && m_tready === 1'b1)
            begin
                if (decoded_due.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("unexpected beat: data=%02h last=%b corrupt=%b",
                                 m_tdata, m_tlast, m_tuser);
                end
                else
                begin
                    want = decoded_due.pop_front();
                    if (m_tdata !== want.data || m_tlast !== want.last ||
                        m_tuser !== want.corrupt)
                    begin
                        fail_count++;
                        if (fail_count <= MAX_REPORTS)
                        begin
                            $display("mismatch: expected data=%02h last=%b corrupt=%b",
                                     want.data, want.last, want.corrupt);
                            $display("          got      data=%02h last=%b corrupt=%b",
                                     m_tdata, m_tlast, m_tuser);
                        end
                    end
                end
                gap = draw_gap(rx_steady);
            end
            else if (gap > 0 && !rx_hold)
                gap--;
            m_tready <= !rx_hold && gap == 0;
        end
    end

    initial
    begin : test_sequence
        wait (rst_n === 1'b1);
        @(posedge clk);
        test_size_zero();
        test_record_kinds();
        test_output_stall();
        test_long_records();
        test_random_records();
        test_end_of_file();
        drain();
        if (decoded_due.size() != 0)
        begin
            fail_count++;
            $display("%0d predicted beats never arrived", decoded_due.size());
        end
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
